>>> rtl/vertical_glyph_substitution_lookup_macros.svh
// Assertion macros shared by the checker of the glyph substitution block.
// Depends on nothing; included by files that assert.
`ifndef VERTICAL_GLYPH_SUBSTITUTION_LOOKUP_MACROS_SVH
`define VERTICAL_GLYPH_SUBSTITUTION_LOOKUP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VGSL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define VGSL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/vgsl_pkg.sv
// Package for the glyph substitution block: word types and codes.
// No dependencies.
`default_nettype none
package vgsl_pkg;

    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_COVER  = 2'd2;
    localparam logic [1:0] KIND_SUBST  = 2'd3;

    // range index sum: up to 127 ranges of 65536 glyphs plus an offset
    localparam int IDX_W = 24;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  table_sel;
        logic [7:0]  entry_index;
        logic [15:0] glyph;
        logic [15:0] range_end;
        logic        cover_format;
        logic        subst_format;
        logic [15:0] delta;
        logic [6:0]  cover_count;
        logic [8:0]  subst_count;
    } req_t;

    typedef struct packed {
        logic [15:0] out_glyph;
        logic        replaced;
        logic        index_error;
    } rsp_t;

    // front queue head toward the back end
    typedef struct packed {
        logic valid;
        req_t word;
    } cmd_t;

endpackage
`default_nettype wire

>>> rtl/vgsl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module vgsl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic                                    rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end
endmodule
`default_nettype wire

>>> rtl/vgsl_front.sv
// Front end: accepts request words, drops ignored loads, saturates counts,
// and queues the rest in a two-entry queue. Depends on vgsl_pkg.
`default_nettype none
module vgsl_front
    import vgsl_pkg::*;
#(
    parameter int MAX_SUBTABLES = 4,
    parameter int COVER_ENTRIES = 64,
    parameter int SUBST_ENTRIES = 256
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output cmd_t      cmd,
    input  wire logic cmd_pop
);
    req_t       q_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       keep, push;
    req_t       clean;

    always_comb
    begin
        clean = req;
        if (32'(req.cover_count) > COVER_ENTRIES)
        begin
            clean.cover_count = 7'(COVER_ENTRIES);
        end
        if (32'(req.subst_count) > SUBST_ENTRIES)
        begin
            clean.subst_count = 9'(SUBST_ENTRIES);
        end
        keep = 1'b0;
        case (req.kind)
            KIND_LOOKUP: keep = 1'b1;
            KIND_HEADER: keep = 32'(req.table_sel) < MAX_SUBTABLES;
            KIND_COVER:  keep = (32'(req.table_sel) < MAX_SUBTABLES)
                                && (32'(req.entry_index) < COVER_ENTRIES);
            KIND_SUBST:  keep = (32'(req.table_sel) < MAX_SUBTABLES)
                                && (32'(req.entry_index) < SUBST_ENTRIES);
            default:     keep = 1'b0;
        endcase
    end

    assign req_ready = (cnt_reg != 2'd2);
    assign push      = req_valid && req_ready && keep;
    assign cmd.valid = (cnt_reg != 2'd0);
    assign cmd.word  = q_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = cmd_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= clean;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

>>> rtl/vgsl_back.sv
// Back end: subtable headers, coverage and substitute RAMs, the lookup
// scan sequencer and the response register. Depends on vgsl_pkg, vgsl_ram.
`default_nettype none
module vgsl_back
    import vgsl_pkg::*;
#(
    parameter int MAX_SUBTABLES = 4,
    parameter int COVER_ENTRIES = 64,
    parameter int SUBST_ENTRIES = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [2:0] active,
    input  wire cmd_t       cmd,
    output logic            cmd_pop,
    output logic            rsp_valid,
    input  wire logic       rsp_ready,
    output rsp_t            rsp
);
    localparam int TW  = (MAX_SUBTABLES > 1) ? $clog2(MAX_SUBTABLES) : 1;
    localparam int NW  = $clog2(MAX_SUBTABLES + 1);
    localparam int CD  = MAX_SUBTABLES * COVER_ENTRIES;
    localparam int SD  = MAX_SUBTABLES * SUBST_ENTRIES;
    localparam int CAW = (CD > 1) ? $clog2(CD) : 1;
    localparam int SAW = (SD > 1) ? $clog2(SD) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_SUBD = 3'd2;
    localparam logic [2:0] ST_RES  = 3'd3;

    logic        hdr_cf_reg [MAX_SUBTABLES];
    logic        hdr_sf_reg [MAX_SUBTABLES];
    logic [15:0] hdr_dl_reg [MAX_SUBTABLES];
    logic [6:0]  hdr_cc_reg [MAX_SUBTABLES];
    logic [8:0]  hdr_sc_reg [MAX_SUBTABLES];

    logic [2:0]  st_reg, st_next;
    logic [NW-1:0] t_reg, t_next, n_act;
    logic [6:0]  i_reg, i_next;
    logic        chk_vld_reg, chk_vld_next;
    logic [TW-1:0] chk_t_reg;
    logic [6:0]  chk_i_reg;
    logic [IDX_W-1:0] sum_reg, sum_next, sum_base, idx;
    logic [15:0] g_reg;
    rsp_t        res_reg, res_next;
    logic        out_vld_reg, out_vld_next;
    rsp_t        out_reg;

    logic        issue;
    logic [TW-1:0] ti;
    logic        cov_we, sub_we, sub_re;
    logic [CAW-1:0] cov_waddr, cov_raddr;
    logic [SAW-1:0] sub_waddr, sub_raddr;
    logic [31:0] cov_rdata;
    logic [15:0] sub_rdata, lo, hi;
    logic        hit, in_rng;

    assign n_act = (32'(active) > MAX_SUBTABLES) ? NW'(MAX_SUBTABLES) : NW'(active);
    assign ti    = TW'(t_reg);
    assign issue = (st_reg == ST_SCAN) && (t_reg < n_act) && (i_reg < hdr_cc_reg[ti]);
    assign cov_raddr = CAW'(CAW'(ti) * CAW'(COVER_ENTRIES) + CAW'(i_reg));

    // load writes, straight from the queue head
    assign cov_we    = (st_reg == ST_IDLE) && cmd.valid && (cmd.word.kind == KIND_COVER);
    assign sub_we    = (st_reg == ST_IDLE) && cmd.valid && (cmd.word.kind == KIND_SUBST);
    assign cov_waddr = CAW'(CAW'(cmd.word.table_sel) * CAW'(COVER_ENTRIES)
                            + CAW'(cmd.word.entry_index));
    assign sub_waddr = SAW'(SAW'(cmd.word.table_sel) * SAW'(SUBST_ENTRIES)
                            + SAW'(cmd.word.entry_index));

    // check stage on the coverage word read last cycle
    assign lo       = cov_rdata[15:0];
    assign hi       = cov_rdata[31:16];
    assign sum_base = (chk_i_reg == 7'd0) ? '0 : sum_reg;
    assign in_rng   = (lo <= g_reg) && (g_reg <= hi);
    assign hit      = chk_vld_reg && (hdr_cf_reg[chk_t_reg] ? in_rng : (lo == g_reg));
    assign idx      = hdr_cf_reg[chk_t_reg] ? (sum_base + IDX_W'(g_reg - lo))
                                            : IDX_W'(chk_i_reg);
    assign sub_re    = hit && hdr_sf_reg[chk_t_reg] && (idx < IDX_W'(hdr_sc_reg[chk_t_reg]));
    assign sub_raddr = SAW'(SAW'(chk_t_reg) * SAW'(SUBST_ENTRIES) + SAW'(idx));

    always_comb
    begin
        sum_next = sum_reg;
        if (chk_vld_reg)
        begin
            sum_next = sum_base;
            if (hdr_cf_reg[chk_t_reg] && (hi >= lo))
            begin
                sum_next = sum_base + IDX_W'(hi - lo) + IDX_W'(1);
            end
        end
    end

    always_comb
    begin
        st_next      = st_reg;
        t_next       = t_reg;
        i_next       = i_reg;
        chk_vld_next = 1'b0;
        res_next     = res_reg;
        out_vld_next = out_vld_reg && !rsp_ready;
        cmd_pop      = 1'b0;
        case (st_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.word.kind == KIND_LOOKUP)
                    begin
                        t_next  = '0;
                        i_next  = '0;
                        st_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    if (!hdr_sf_reg[chk_t_reg])
                    begin
                        res_next = '{g_reg + hdr_dl_reg[chk_t_reg], 1'b1, 1'b0};
                        st_next  = ST_RES;
                    end
                    else if (sub_re)
                    begin
                        st_next = ST_SUBD;
                    end
                    else
                    begin
                        res_next = '{g_reg, 1'b0, 1'b1};
                        st_next  = ST_RES;
                    end
                end
                else if (issue)
                begin
                    chk_vld_next = 1'b1;
                    i_next       = i_reg + 7'd1;
                end
                else if (t_reg < n_act)
                begin
                    t_next = t_reg + NW'(1);
                    i_next = '0;
                end
                else if (!chk_vld_reg)
                begin
                    res_next = '{g_reg, 1'b0, 1'b0};
                    st_next  = ST_RES;
                end
            end
            ST_SUBD:
            begin
                res_next = '{sub_rdata, 1'b1, 1'b0};
                st_next  = ST_RES;
            end
            ST_RES:
            begin
                if (!out_vld_reg || rsp_ready)
                begin
                    out_vld_next = 1'b1;
                    st_next      = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    vgsl_ram #(.WIDTH(32), .DEPTH(CD)) u_cov (
        .clk     (clk),
        .wr_en   (cov_we),
        .wr_addr (cov_waddr),
        .wr_data ({cmd.word.range_end, cmd.word.glyph}),
        .rd_en   (issue),
        .rd_addr (cov_raddr),
        .rd_data (cov_rdata)
    );

    vgsl_ram #(.WIDTH(16), .DEPTH(SD)) u_sub (
        .clk     (clk),
        .wr_en   (sub_we),
        .wr_addr (sub_waddr),
        .wr_data (cmd.word.glyph),
        .rd_en   (sub_re),
        .rd_addr (sub_raddr),
        .rd_data (sub_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && cmd.valid && cmd.word.kind == KIND_LOOKUP)
        begin
            g_reg <= cmd.word.glyph;
        end
        if (issue)
        begin
            chk_t_reg <= ti;
            chk_i_reg <= i_reg;
        end
        sum_reg <= sum_next;
        res_reg <= res_next;
        if (st_reg == ST_RES && (!out_vld_reg || rsp_ready))
        begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= ST_IDLE;
            t_reg       <= '0;
            i_reg       <= '0;
            chk_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k < MAX_SUBTABLES; k++)
            begin
                hdr_cf_reg[k] <= 1'b0;
                hdr_sf_reg[k] <= 1'b0;
                hdr_dl_reg[k] <= '0;
                hdr_cc_reg[k] <= '0;
                hdr_sc_reg[k] <= '0;
            end
        end
        else
        begin
            st_reg      <= st_next;
            t_reg       <= t_next;
            i_reg       <= i_next;
            chk_vld_reg <= chk_vld_next;
            out_vld_reg <= out_vld_next;
            if (st_reg == ST_IDLE && cmd.valid && cmd.word.kind == KIND_HEADER)
            begin
                hdr_cf_reg[TW'(cmd.word.table_sel)] <= cmd.word.cover_format;
                hdr_sf_reg[TW'(cmd.word.table_sel)] <= cmd.word.subst_format;
                hdr_dl_reg[TW'(cmd.word.table_sel)] <= cmd.word.delta;
                hdr_cc_reg[TW'(cmd.word.table_sel)] <= cmd.word.cover_count;
                hdr_sc_reg[TW'(cmd.word.table_sel)] <= cmd.word.subst_count;
            end
        end
    end

    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;
endmodule
`default_nettype wire

>>> rtl/vertical_glyph_substitution_lookup.sv
// Top level of the glyph substitution lookup engine.
// Depends on vgsl_pkg, vgsl_front, vgsl_back (and vgsl_ram below it).
//
//  channel | direction | word     | handshake
//  req     | in        | req_t    | req_valid / req_ready
//  rsp     | out       | rsp_t    | rsp_valid / rsp_ready
//  cfg     | in        | 3 bits   | cfg_valid / cfg_ready (always ready)
//
// Load words are taken by the back end only while it is idle. A lookup
// scans the active subtables in order, one coverage RAM read per entry
// scanned; list-format hits add one substitute RAM read.
// Reset clears headers and control; the RAMs are not cleared.
// A two-word queue lets requests keep arriving while a response stalls.
`default_nettype none
module vertical_glyph_substitution_lookup
    import vgsl_pkg::*;
#(
    parameter int MAX_SUBTABLES = 4,
    parameter int COVER_ENTRIES = 64,
    parameter int SUBST_ENTRIES = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire req_t       req,
    output logic            rsp_valid,
    input  wire logic       rsp_ready,
    output rsp_t            rsp,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_data
);
    logic [2:0] active_reg;
    cmd_t       cmd;
    logic       cmd_pop;

    // config register; the user must write it only while idle, the block does not enforce this
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 3'd0;
        end
        else if (cfg_valid)
        begin
            active_reg <= cfg_data;
        end
    end

    vgsl_front #(
        .MAX_SUBTABLES (MAX_SUBTABLES),
        .COVER_ENTRIES (COVER_ENTRIES),
        .SUBST_ENTRIES (SUBST_ENTRIES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    vgsl_back #(
        .MAX_SUBTABLES (MAX_SUBTABLES),
        .COVER_ENTRIES (COVER_ENTRIES),
        .SUBST_ENTRIES (SUBST_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .active    (active_reg),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );
endmodule
`default_nettype wire

>>> rtl/vgsl_checker.sv
// Port-level checker for the glyph substitution block, with its bind.
// Depends on vgsl_pkg and the assertion macro header.
`default_nettype none
`include "vertical_glyph_substitution_lookup_macros.svh"
module vgsl_checker
    import vgsl_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_valid,
    input wire logic       req_ready,
    input wire req_t       req,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire rsp_t       rsp,
    input wire logic       cfg_valid,
    input wire logic       cfg_ready,
    input wire logic [2:0] cfg_data
);
    // lookups accepted and not yet answered
    logic [2:0] pend_reg;
    logic       lk_in, rsp_out;

    assign lk_in   = req_valid && req_ready && (req.kind == KIND_LOOKUP);
    assign rsp_out = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 3'd0;
        end
        else
        begin
            pend_reg <= pend_reg + 3'(lk_in) - 3'(rsp_out);
        end
    end

    `VGSL_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
    `VGSL_ASSERT_IMP(a_rsp_owed, clk, rst_n, rsp_valid, pend_reg != 3'd0)
    `VGSL_ASSERT_IMP(a_cfg_rdy, clk, rst_n, cfg_valid || !cfg_valid, cfg_ready)
    `VGSL_ASSERT_IMP(a_no_ovf, clk, rst_n, 1'b1, pend_reg <= 3'd5 && cfg_data == cfg_data)
endmodule

bind vertical_glyph_substitution_lookup vgsl_checker u_vgsl_checker (.*);
`default_nettype wire

>>> sim/vertical_glyph_substitution_lookup_tb.sv
// Self-checking testbench for the glyph substitution lookup engine.
// Depends on vgsl_pkg and the vertical_glyph_substitution_lookup RTL.
// Load words build subtables, lookups are checked against an in-bench predictor.
`default_nettype none
module vertical_glyph_substitution_lookup_tb;
    import vgsl_pkg::*;

    localparam int NTAB   = 4;
    localparam int NCOVER = 64;
    localparam int NSUBST = 256;
    // longest lookup: a scan of every entry of four full subtables plus a substitute read, with margin
    localparam int SETTLE = 400;
    localparam int TARGET = 1750;

    // Predictor of the engine plus the queue of pending lookup answers.
    // Written-entry flags let the stimulus steer clear of never-written entries.
    class glyph_scoreboard;
        logic [2:0]  active;
        bit          cov_fmt[NTAB];
        bit          sub_fmt[NTAB];
        logic [15:0] delta[NTAB];
        int          cov_cnt[NTAB];
        int          sub_cnt[NTAB];
        logic [15:0] cov_lo[NTAB*NCOVER];
        logic [15:0] cov_hi[NTAB*NCOVER];
        bit          cov_set[NTAB*NCOVER];
        logic [15:0] sub_glyph[NTAB*NSUBST];
        bit          sub_set[NTAB*NSUBST];
        rsp_t        answers_q[$];
        int          errors;

        function new();
            active = '0;
            errors = 0;
            for (int t = 0; t < NTAB; t++)
            begin
                cov_fmt[t] = 0;
                sub_fmt[t] = 0;
                delta[t]   = '0;
                cov_cnt[t] = 0;
                sub_cnt[t] = 0;
            end
            foreach (cov_set[k])
                cov_set[k] = 0;
            foreach (sub_set[k])
                sub_set[k] = 0;
        endfunction

        // answer for a coverage hit at index idx of subtable t
        function void answer(int t, logic [15:0] g, int idx, inout rsp_t r, inout bit blank);
            logic [15:0] sum16;
            int k;
            sum16 = g + delta[t];
            if (!sub_fmt[t])
            begin
                r.out_glyph = sum16;
                r.replaced = 1'b1;
            end
            else if (idx < sub_cnt[t])
            begin
                k = t * NSUBST + idx;
                if (!sub_set[k])
                    blank = 1;
                r.out_glyph = sub_glyph[k];
                r.replaced = 1'b1;
            end
            else
                r.index_error = 1'b1;
        endfunction

        // blank is set when the search would touch a never-written entry
        function void lookup(logic [15:0] g, output rsp_t r, output bit blank);
            int n;
            int sum;
            int k;
            r.out_glyph = g;
            r.replaced = 1'b0;
            r.index_error = 1'b0;
            blank = 0;
            n = (active > NTAB) ? NTAB : active;
            for (int t = 0; t < n; t++)
            begin
                sum = 0;
                for (int i = 0; i < cov_cnt[t]; i++)
                begin
                    k = t * NCOVER + i;
                    if (!cov_set[k])
                        blank = 1;
                    if (!cov_fmt[t])
                    begin
                        if (cov_lo[k] == g)
                        begin
                            answer(t, g, i, r, blank);
                            return;
                        end
                    end
                    else
                    begin
                        if (cov_lo[k] <= g && g <= cov_hi[k])
                        begin
                            answer(t, g, sum + int'(g) - int'(cov_lo[k]), r, blank);
                            return;
                        end
                        // reversed range adds nothing to the index sum
                        if (cov_hi[k] >= cov_lo[k])
                            sum += int'(cov_hi[k]) - int'(cov_lo[k]) + 1;
                    end
                end
            end
        endfunction

        function void note_word(req_t w);
            rsp_t r;
            bit blank;
            int t;
            t = w.table_sel;
            case (w.kind)
                KIND_LOOKUP:
                begin
                    lookup(w.glyph, r, blank);
                    answers_q.push_back(r);
                end
                KIND_HEADER:
                begin
                    cov_fmt[t] = w.cover_format;
                    sub_fmt[t] = w.subst_format;
                    delta[t]   = w.delta;
                    cov_cnt[t] = (w.cover_count > NCOVER) ? NCOVER : w.cover_count;
                    sub_cnt[t] = (w.subst_count > NSUBST) ? NSUBST : w.subst_count;
                end
                KIND_COVER:
                begin
                    if (w.entry_index < NCOVER)
                    begin
                        cov_lo[t*NCOVER + w.entry_index]  = w.glyph;
                        cov_hi[t*NCOVER + w.entry_index]  = w.range_end;
                        cov_set[t*NCOVER + w.entry_index] = 1;
                    end
                end
                default:
                begin
                    sub_glyph[t*NSUBST + w.entry_index] = w.glyph;
                    sub_set[t*NSUBST + w.entry_index]   = 1;
                end
            endcase
        endfunction

        function void check_word(rsp_t got);
            rsp_t exp_r;
            if (answers_q.size() == 0)
            begin
                $error("unexpected response word %h", got);
                errors++;
                return;
            end
            exp_r = answers_q.pop_front();
            if (got.out_glyph !== exp_r.out_glyph)
            begin
                $error("out_glyph: expected %h, got %h", exp_r.out_glyph, got.out_glyph);
                errors++;
            end
            if (got.replaced !== exp_r.replaced)
            begin
                $error("replaced: expected %b, got %b", exp_r.replaced, got.replaced);
                errors++;
            end
            if (got.index_error !== exp_r.index_error)
            begin
                $error("index_error: expected %b, got %b", exp_r.index_error, got.index_error);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_ready;
    req_t       req;
    logic       rsp_valid;
    logic       rsp_ready;
    rsp_t       rsp;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_data;

    glyph_scoreboard sb = new();
    bit steady;          // no idling on either side while set
    int rsp_hold;        // cycles the response side still holds off
    int words_sent;

    vertical_glyph_substitution_lookup u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // Response side: random back-pressure, or a long hold when asked.
    always @(posedge clk)
    begin
        if (rsp_hold > 0)
        begin
            rsp_ready <= 1'b0;
            rsp_hold  <= rsp_hold - 1;
        end
        else
            rsp_ready <= steady || ($urandom_range(99) >= 33);
    end

    // Every handshake is seen here, so the predictor follows acceptance order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.active = cfg_data;
            if (req_valid && req_ready)
                sb.note_word(req);
            if (rsp_valid && rsp_ready)
                sb.check_word(rsp);
        end
    end

    // Fully random word; callers overwrite the fields that matter.
    function automatic req_t random_word();
        req_t w;
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        w = bits[$bits(req_t)-1:0];
        return w;
    endfunction

    function automatic req_t load_word(logic [1:0] k, int t, int ei, int g, int re);
        req_t w;
        w = random_word();
        w.kind        = k;
        w.table_sel   = 2'(t);
        w.entry_index = 8'(ei);
        w.glyph       = 16'(g);
        w.range_end   = 16'(re);
        return w;
    endfunction

    task automatic send_word(req_t w);
        if (!steady && $urandom_range(99) < 33)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        words_sent++;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // Register writes only with the engine idle: drain, then let a lookup finish.
    task automatic write_active(logic [2:0] v);
        req_valid <= 1'b0;
        while (sb.answers_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_header(int t, bit cf, bit sf, int d, int cc, int sc);
        req_t w;
        w = load_word(KIND_HEADER, t, $urandom, $urandom, $urandom);
        w.cover_format = cf;
        w.subst_format = sf;
        w.delta        = 16'(d);
        w.cover_count  = 7'(cc);
        w.subst_count  = 9'(sc);
        send_word(w);
    endtask

    // Well-formed subtable: header, every coverage entry, then substitutes if list format.
    task automatic build_subtable(int t, bit big);
        int cc;
        int sc;
        int lo;
        int hi;
        bit cf;
        bit sf;
        cf = 1'($urandom);
        sf = 1'($urandom);
        cc = big ? $urandom_range(64, 127) : $urandom_range(0, 8);
        sc = (big && $urandom_range(1)) ? $urandom_range(256, 511) : $urandom_range(0, 12);
        send_header(t, cf, sf, $urandom, cc, sc);
        if (cc > NCOVER)
            cc = NCOVER;
        if (sc > NSUBST)
            sc = NSUBST;
        for (int i = 0; i < cc; i++)
        begin
            lo = ($urandom_range(3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 65535);
            case ($urandom_range(9))
                0:
                begin
                    // reversed range
                    lo = $urandom_range(1, 65535);
                    hi = $urandom_range(0, lo - 1);
                end
                1:
                begin
                    lo = 0;
                    hi = 65535;
                end
                2:
                    hi = 65535;
                default:
                    hi = (lo + $urandom_range(0, 4) > 65535) ? 65535 : lo + $urandom_range(0, 4);
            endcase
            if (!cf)
                hi = $urandom;
            send_word(load_word(KIND_COVER, t, i, lo, hi));
        end
        if (sf)
            for (int i = 0; i < sc; i++)
                send_word(load_word(KIND_SUBST, t, i, $urandom, $urandom));
    endtask

    // Lookup aimed mostly at covered glyphs; skipped if it would read blank entries.
    task automatic send_lookup();
        req_t w;
        rsp_t r;
        bit blank;
        int n;
        int t;
        int k;
        for (int tries = 0; tries < 8; tries++)
        begin
            w = random_word();
            w.kind = KIND_LOOKUP;
            n = (sb.active > NTAB) ? NTAB : sb.active;
            if (n > 0 && $urandom_range(9) < 7)
            begin
                t = $urandom_range(0, n - 1);
                if (sb.cov_cnt[t] > 0)
                begin
                    k = t * NCOVER + $urandom_range(0, sb.cov_cnt[t] - 1);
                    w.glyph = sb.cov_lo[k];
                    if (sb.cov_fmt[t] && sb.cov_hi[k] > sb.cov_lo[k])
                        w.glyph = 16'(sb.cov_lo[k]
                                      + $urandom_range(0, sb.cov_hi[k] - sb.cov_lo[k]));
                end
            end
            sb.lookup(w.glyph, r, blank);
            if (!blank)
            begin
                send_word(w);
                return;
            end
        end
    endtask

    // Stray load words: overwrites, out-of-range coverage slots, rare headers.
    task automatic send_noise();
        req_t w;
        w = random_word();
        case ($urandom_range(19))
            0:
                w.kind = KIND_HEADER;
            1, 2, 3, 4, 5, 6, 7, 8, 9:
                w.kind = KIND_COVER;
            default:
                w.kind = KIND_SUBST;
        endcase
        send_word(w);
    endtask

    initial
    begin
        logic [2:0] settings[10];
        int ph;
        settings   = '{3'd4, 3'd1, 3'd2, 3'd3, 3'd0, 3'd4, 3'd7, 3'd5, 3'd6, 3'd4};
        rst_n      <= 1'b0;
        req_valid  <= 1'b0;
        req        <= '0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        rsp_ready  <= 1'b0;
        rsp_hold   = 0;
        steady     = 0;
        words_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: nothing active, then the corner cases of each format.
        send_word(load_word(KIND_LOOKUP, 0, 0, 16'h0000, 0));
        send_word(load_word(KIND_LOOKUP, 0, 0, 16'hFFFF, 0));
        send_header(0, 1'b0, 1'b0, 16'hFFFF, 2, 0);
        send_word(load_word(KIND_COVER, 0, 0, 16'h0000, 0));
        send_word(load_word(KIND_COVER, 0, 1, 16'hFFFF, 0));
        send_header(1, 1'b1, 1'b1, 0, 3, 4);
        send_word(load_word(KIND_COVER, 1, 0, 16'h0100, 16'h0102));
        send_word(load_word(KIND_COVER, 1, 1, 16'h0200, 16'h01F0));
        send_word(load_word(KIND_COVER, 1, 2, 16'h0300, 16'h0305));
        send_word(load_word(KIND_COVER, 1, 200, 16'h0400, 16'h0400));
        for (int i = 0; i < 4; i++)
            send_word(load_word(KIND_SUBST, 1, i, 16'hA000 + i, 0));
        write_active(3'd2);
        send_word(load_word(KIND_LOOKUP, 0, 0, 16'h0000, 0));
        send_word(load_word(KIND_LOOKUP, 0, 0, 16'hFFFF, 0));
        send_word(load_word(KIND_LOOKUP, 0, 0, 16'h0101, 0));
        send_word(load_word(KIND_LOOKUP, 0, 0, 16'h0300, 0));
        send_word(load_word(KIND_LOOKUP, 0, 0, 16'h0301, 0));
        send_word(load_word(KIND_LOOKUP, 0, 0, 16'h01F5, 0));
        send_word(load_word(KIND_LOOKUP, 0, 0, 16'h0400, 0));

        // Random phases, each under its own register setting.
        ph = 0;
        while (words_sent < TARGET)
        begin
            write_active(settings[ph % 10]);
            steady = (ph == 3);
            for (int t = 0; t < NTAB; t++)
                build_subtable(t, $urandom_range(9) == 0);
            // one phase stalls the response side long enough to back up the input
            if (ph == 1)
                rsp_hold = 3000;
            for (int i = 0; i < 180 && words_sent < TARGET; i++)
            begin
                if ($urandom_range(9) < 8)
                    send_lookup();
                else
                    send_noise();
            end
            ph++;
        end
        steady = 0;

        req_valid <= 1'b0;
        while (sb.answers_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (sb.errors == 0 && sb.answers_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #50000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
